@@ rtl/midpoint_ellipse_rasterizer_defines.svh @@
// Assertion helpers shared by the RTL files that check their own logic.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define MER_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mer_pkg.sv @@
`timescale 1ns / 1ps

package mer_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int AXIS_BITS_DEF  = 11;
    localparam int FIFO_DEPTH     = 2;
    localparam int PIX_PER_POINT  = 4;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef struct packed {
        logic go;
        logic fin;
        logic last;
    } t_emit_ctl;

endpackage

@@ rtl/mer_if.sv @@
`timescale 1ns / 1ps

interface mer_cmd_if #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [AXIS_BITS-1:0]  radius_x;
    logic [AXIS_BITS-1:0]  radius_y;

    modport source (output valid, opcode, center_x, center_y, radius_x, radius_y,
                    input ready);
    modport sink (input valid, opcode, center_x, center_y, radius_x, radius_y,
                  output ready);
endinterface

interface mer_pix_if #(
    parameter int PIX_BITS = mer_pkg::COORD_BITS_DEF + 2
);
    logic                       valid;
    logic                       ready;
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic                       last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

@@ rtl/mer_front.sv @@
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_defines.svh"

module mer_front #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mer_cmd_if.sink               i_cmd,
    output logic                  o_valid,
    input  logic                  i_pop,
    output logic                  o_kind,
    output logic [COORD_BITS-1:0] o_cx,
    output logic [COORD_BITS-1:0] o_cy,
    output logic [AXIS_BITS-1:0]  o_a,
    output logic [AXIS_BITS-1:0]  o_b
);
    import mer_pkg::*;

    localparam int PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

    logic                  r_kind [FIFO_DEPTH];
    logic [COORD_BITS-1:0] r_cx   [FIFO_DEPTH];
    logic [COORD_BITS-1:0] r_cy   [FIFO_DEPTH];
    logic [AXIS_BITS-1:0]  r_a    [FIFO_DEPTH];
    logic [AXIS_BITS-1:0]  r_b    [FIFO_DEPTH];

    logic [PTR_BITS-1:0] r_wp, n_wp;
    logic [PTR_BITS-1:0] r_rp, n_rp;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                w_push;
    logic                w_kind;

    // Only bit zero of the opcode selects the command.
    assign w_kind = i_cmd.opcode ? KIND_STEP : KIND_START;

    assign i_cmd.ready = (r_cnt != CNT_BITS'(FIFO_DEPTH));
    assign w_push      = i_cmd.valid && i_cmd.ready;

    assign o_valid = (r_cnt != '0);
    assign o_kind  = r_kind[r_rp];
    assign o_cx    = r_cx[r_rp];
    assign o_cy    = r_cy[r_rp];
    assign o_a     = r_a[r_rp];
    assign o_b     = r_b[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_wp + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_rp + PTR_BITS'(1);
        end
        if (w_push && !i_pop) begin
            n_cnt = r_cnt + CNT_BITS'(1);
        end else if (!w_push && i_pop) begin
            n_cnt = r_cnt - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_kind[r_wp] <= w_kind;
            r_cx[r_wp]   <= i_cmd.center_x;
            r_cy[r_wp]   <= i_cmd.center_y;
            r_a[r_wp]    <= i_cmd.radius_x;
            r_b[r_wp]    <= i_cmd.radius_y;
        end
    end

    `MER_ASSERT(a_cnt_bound, r_cnt <= CNT_BITS'(FIFO_DEPTH), "queue count exceeds depth")
    `MER_ASSERT(a_pop_nonempty, i_pop |-> (r_cnt != '0), "pop from an empty queue")
    `MER_ASSERT_NEXT(a_push_grows, w_push && !i_pop, r_cnt == $past(r_cnt) + CNT_BITS'(1), "queue count did not grow")

endmodule

@@ rtl/mer_core.sv @@
`timescale 1ns / 1ps

module mer_core #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_pop,
    input  logic                       i_kind,
    input  logic [COORD_BITS-1:0]      i_cx,
    input  logic [COORD_BITS-1:0]      i_cy,
    input  logic [AXIS_BITS-1:0]       i_a,
    input  logic [AXIS_BITS-1:0]       i_b,
    input  logic                       i_emit_busy,
    output mer_pkg::t_emit_ctl         o_ctl,
    output logic [AXIS_BITS:0]         o_x,
    output logic signed [AXIS_BITS:0]  o_y,
    output logic [COORD_BITS-1:0]      o_ox,
    output logic [COORD_BITS-1:0]      o_oy
);
    import mer_pkg::*;

    localparam int PT_BITS  = AXIS_BITS + 1;
    localparam int SQ_BITS  = 2 * AXIS_BITS;
    localparam int MUL_BITS = 2 * AXIS_BITS + 2;
    localparam int DEC_BITS = 2 * MUL_BITS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_S0   = 4'd1;
    localparam logic [3:0] ST_S1   = 4'd2;
    localparam logic [3:0] ST_S2   = 4'd3;
    localparam logic [3:0] ST_S3   = 4'd4;
    localparam logic [3:0] ST_A    = 4'd5;
    localparam logic [3:0] ST_M1   = 4'd6;
    localparam logic [3:0] ST_M2   = 4'd7;
    localparam logic [3:0] ST_M3   = 4'd8;
    localparam logic [3:0] ST_E1   = 4'd9;
    localparam logic [3:0] ST_E2   = 4'd10;
    localparam logic [3:0] ST_E3   = 4'd11;
    localparam logic [3:0] ST_E4   = 4'd12;
    localparam logic [3:0] ST_E5   = 4'd13;
    localparam logic [3:0] ST_E6   = 4'd14;

    logic [3:0]                  r_state, n_state;
    logic                        r_busy, n_busy;
    logic                        r_r2, n_r2;
    logic                        r_step, n_step;
    logic                        r_incx, n_incx;
    logic                        r_usey, n_usey;
    logic [PT_BITS-1:0]          r_x, n_x;
    logic signed [PT_BITS-1:0]   r_y, n_y;
    logic [COORD_BITS-1:0]       r_ox, n_ox;
    logic [COORD_BITS-1:0]       r_oy, n_oy;
    logic [AXIS_BITS-1:0]        r_a, n_a;
    logic [SQ_BITS-1:0]          r_a2, n_a2;
    logic [SQ_BITS-1:0]          r_b2, n_b2;
    logic signed [DEC_BITS-1:0]  r_d, n_d;
    logic signed [DEC_BITS-1:0]  r_t, n_t;
    logic signed [MUL_BITS-1:0]  r_u, n_u;
    logic signed [DEC_BITS-1:0]  r_prod;

    logic signed [MUL_BITS-1:0]  w_ma, w_mb;
    logic signed [DEC_BITS-1:0]  w_mul;
    logic signed [MUL_BITS-1:0]  w_x_m, w_y_m, w_ym1_m, w_a_m, w_a2_m, w_b2_m;
    logic signed [DEC_BITS-1:0]  w_x_d, w_a2_d, w_b2_d;
    logic                        w_d_pos;

    assign w_x_m   = {{(MUL_BITS - PT_BITS){1'b0}}, r_x};
    assign w_y_m   = {{(MUL_BITS - PT_BITS){r_y[PT_BITS-1]}}, r_y};
    assign w_ym1_m = w_y_m - MUL_BITS'(1);
    assign w_a_m   = {{(MUL_BITS - AXIS_BITS){1'b0}}, r_a};
    assign w_a2_m  = {{(MUL_BITS - SQ_BITS){1'b0}}, r_a2};
    assign w_b2_m  = {{(MUL_BITS - SQ_BITS){1'b0}}, r_b2};
    assign w_x_d   = {{(DEC_BITS - PT_BITS){1'b0}}, r_x};
    assign w_a2_d  = {{(DEC_BITS - SQ_BITS){1'b0}}, r_a2};
    assign w_b2_d  = {{(DEC_BITS - SQ_BITS){1'b0}}, r_b2};
    assign w_d_pos = !r_d[DEC_BITS-1] && (r_d != '0);

    always_comb begin
        case (r_state)
            ST_S0: begin
                w_ma = w_a_m;
                w_mb = w_a_m;
            end
            ST_S1: begin
                w_ma = w_y_m;
                w_mb = w_y_m;
            end
            ST_S2: begin
                w_ma = w_a2_m;
                w_mb = w_y_m;
            end
            ST_M1: begin
                w_ma = w_b2_m;
                w_mb = w_x_m;
            end
            ST_M2: begin
                w_ma = w_a2_m;
                w_mb = w_y_m;
            end
            ST_E1: begin
                w_ma = w_x_m;
                w_mb = w_x_m;
            end
            ST_E2: begin
                w_ma = w_ym1_m;
                w_mb = w_ym1_m;
            end
            ST_E3: begin
                w_ma = w_b2_m;
                w_mb = r_t[MUL_BITS-1:0];
            end
            ST_E4: begin
                w_ma = w_a2_m;
                w_mb = r_u;
            end
            ST_E5: begin
                w_ma = w_a2_m;
                w_mb = w_b2_m;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mul = DEC_BITS'(w_ma) * DEC_BITS'(w_mb);

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_r2    = r_r2;
        n_step  = r_step;
        n_incx  = r_incx;
        n_usey  = r_usey;
        n_x     = r_x;
        n_y     = r_y;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_a     = r_a;
        n_a2    = r_a2;
        n_b2    = r_b2;
        n_d     = r_d;
        n_t     = r_t;
        n_u     = r_u;
        o_pop   = 1'b0;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && !i_emit_busy) begin
                    o_pop = 1'b1;
                    if (i_kind == KIND_START) begin
                        n_ox    = i_cx;
                        n_oy    = i_cy;
                        n_a     = i_a;
                        n_x     = '0;
                        n_y     = {1'b0, i_b};
                        n_r2    = 1'b0;
                        n_busy  = 1'b1;
                        n_step  = 1'b0;
                        n_state = ST_S0;
                    end else if (r_busy) begin
                        o_ctl.go = 1'b1;
                        n_step   = 1'b1;
                        n_state  = ST_A;
                    end
                end
            end
            ST_S0: begin
                n_state = ST_S1;
            end
            ST_S1: begin
                n_a2    = r_prod[SQ_BITS-1:0];
                n_state = ST_S2;
            end
            ST_S2: begin
                n_b2    = r_prod[SQ_BITS-1:0];
                n_state = ST_S3;
            end
            ST_S3: begin
                n_d = w_b2_d - r_prod + (w_a2_d >>> 2);
                if (!r_prod[DEC_BITS-1] && (r_prod != '0)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_E1;
                end
            end
            ST_A: begin
                if (!r_r2) begin
                    n_x    = r_x + PT_BITS'(1);
                    n_incx = 1'b1;
                    n_usey = !r_d[DEC_BITS-1];
                    if (!r_d[DEC_BITS-1]) begin
                        n_y = r_y - PT_BITS'(1);
                    end
                end else begin
                    n_y    = r_y - PT_BITS'(1);
                    n_usey = 1'b1;
                    n_incx = !w_d_pos;
                    if (!w_d_pos) begin
                        n_x = r_x + PT_BITS'(1);
                    end
                end
                n_state = ST_M1;
            end
            ST_M1: begin
                n_state = ST_M2;
            end
            ST_M2: begin
                n_t     = r_prod;
                n_state = ST_M3;
            end
            ST_M3: begin
                n_d = r_d + (r_incx ? (r_t <<< 1) : '0) - (r_usey ? (r_prod <<< 1) : '0)
                    + (r_r2 ? w_a2_d : w_b2_d);
                if (!r_r2 && !(r_t < r_prod)) begin
                    n_state = ST_E1;
                end else begin
                    n_state   = ST_IDLE;
                    o_ctl.fin = 1'b1;
                    if (r_r2 && r_y[PT_BITS-1]) begin
                        o_ctl.last = 1'b1;
                        n_busy     = 1'b0;
                    end
                end
            end
            ST_E1: begin
                n_state = ST_E2;
            end
            ST_E2: begin
                n_t     = r_prod + w_x_d;
                n_state = ST_E3;
            end
            ST_E3: begin
                n_u     = r_prod[MUL_BITS-1:0];
                n_state = ST_E4;
            end
            ST_E4: begin
                n_t     = r_prod + (w_b2_d >>> 2);
                n_state = ST_E5;
            end
            ST_E5: begin
                n_t     = r_t + r_prod;
                n_state = ST_E6;
            end
            ST_E6: begin
                n_d     = r_t - r_prod;
                n_r2    = 1'b1;
                n_state = ST_IDLE;
                if (r_y[PT_BITS-1]) begin
                    n_busy = 1'b0;
                end
                if (r_step) begin
                    o_ctl.fin  = 1'b1;
                    o_ctl.last = r_y[PT_BITS-1];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_r2    <= 1'b0;
            r_step  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_r2    <= n_r2;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_incx <= n_incx;
        r_usey <= n_usey;
        r_x    <= n_x;
        r_y    <= n_y;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_a    <= n_a;
        r_a2   <= n_a2;
        r_b2   <= n_b2;
        r_d    <= n_d;
        r_t    <= n_t;
        r_u    <= n_u;
        r_prod <= w_mul;
    end

    assign o_x  = r_x;
    assign o_y  = r_y;
    assign o_ox = r_ox;
    assign o_oy = r_oy;

endmodule

@@ rtl/mer_emit.sv @@
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_defines.svh"

module mer_emit #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mer_pkg::t_emit_ctl         i_ctl,
    input  logic [AXIS_BITS:0]         i_x,
    input  logic signed [AXIS_BITS:0]  i_y,
    input  logic [COORD_BITS-1:0]      i_ox,
    input  logic [COORD_BITS-1:0]      i_oy,
    output logic                       o_busy,
    mer_pix_if.source                  o_pix
);
    import mer_pkg::*;

    localparam int PT_BITS  = AXIS_BITS + 1;
    localparam int PIX_BITS = COORD_BITS + 2;
    localparam int SUM_BITS = ((COORD_BITS > PT_BITS) ? COORD_BITS : PT_BITS) + 2;
    localparam int K_BITS   = $clog2(PIX_PER_POINT);
    localparam logic [K_BITS-1:0] LAST_K = K_BITS'(PIX_PER_POINT - 1);

    logic                       r_active, n_active;
    logic                       r_fin, n_fin;
    logic                       r_lastf, n_lastf;
    logic [K_BITS-1:0]          r_k, n_k;
    logic [PT_BITS-1:0]         r_x, n_x;
    logic signed [PT_BITS-1:0]  r_y, n_y;
    logic [COORD_BITS-1:0]      r_ox, n_ox;
    logic [COORD_BITS-1:0]      r_oy, n_oy;
    logic                       r_valid, n_valid;
    logic [PIX_BITS-1:0]        r_px, n_px;
    logic [PIX_BITS-1:0]        r_py, n_py;
    logic                       r_last, n_last;

    logic                       w_slot;
    logic                       w_load;
    logic signed [SUM_BITS-1:0] w_ox_s, w_oy_s, w_x_s, w_y_s, w_sx, w_sy;

    assign w_ox_s = {{(SUM_BITS - COORD_BITS){1'b0}}, r_ox};
    assign w_oy_s = {{(SUM_BITS - COORD_BITS){1'b0}}, r_oy};
    assign w_x_s  = {{(SUM_BITS - PT_BITS){1'b0}}, r_x};
    assign w_y_s  = {{(SUM_BITS - PT_BITS){r_y[PT_BITS-1]}}, r_y};

    // Bit zero of the pixel index mirrors in x, bit one mirrors in y.
    assign w_sx = r_k[0] ? (w_ox_s - w_x_s) : (w_ox_s + w_x_s);
    assign w_sy = r_k[1] ? (w_oy_s - w_y_s) : (w_oy_s + w_y_s);

    assign w_slot = !r_valid || o_pix.ready;
    assign w_load = r_active && w_slot && ((r_k != LAST_K) || r_fin);

    always_comb begin
        n_active = r_active;
        n_fin    = r_fin;
        n_lastf  = r_lastf;
        n_k      = r_k;
        n_x      = r_x;
        n_y      = r_y;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_valid  = r_valid;
        n_px     = r_px;
        n_py     = r_py;
        n_last   = r_last;
        if (w_slot) begin
            n_valid = 1'b0;
        end
        if (w_load) begin
            n_valid = 1'b1;
            n_px    = w_sx[PIX_BITS-1:0];
            n_py    = w_sy[PIX_BITS-1:0];
            n_last  = (r_k == LAST_K) && r_lastf;
            n_k     = r_k + K_BITS'(1);
            if (r_k == LAST_K) begin
                n_active = 1'b0;
            end
        end
        if (i_ctl.go) begin
            n_active = 1'b1;
            n_k      = '0;
            n_fin    = 1'b0;
            n_x      = i_x;
            n_y      = i_y;
            n_ox     = i_ox;
            n_oy     = i_oy;
        end
        if (i_ctl.fin) begin
            n_fin   = 1'b1;
            n_lastf = i_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_fin    <= 1'b0;
            r_valid  <= 1'b0;
            r_k      <= '0;
        end else begin
            r_active <= n_active;
            r_fin    <= n_fin;
            r_valid  <= n_valid;
            r_k      <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lastf <= n_lastf;
        r_x     <= n_x;
        r_y     <= n_y;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_px    <= n_px;
        r_py    <= n_py;
        r_last  <= n_last;
    end

    assign o_busy           = r_active;
    assign o_pix.valid      = r_valid;
    assign o_pix.pixel_x    = r_px;
    assign o_pix.pixel_y    = r_py;
    assign o_pix.last_pixel = r_last;

    `MER_ASSERT(a_go_idle, i_ctl.go |-> !r_active, "new point while pixels still pending")
    `MER_ASSERT(a_fin_once, i_ctl.fin |-> (r_active && !r_fin), "completion without a point in flight")
    `MER_ASSERT(a_last_waits, (w_load && (r_k == LAST_K)) |-> r_fin, "final pixel sent before update")

endmodule

@@ rtl/midpoint_ellipse_rasterizer.sv @@
`timescale 1ns / 1ps
// A step yields four pixels, each held while the output is not ready; the fourth also waits
// for the sequencer to finish the point update, and no command is taken before all four are
// loaded. A step runs states A, M1 to M3 (E1 to E6 on entering region two), a start S0 to S3
// (E1 to E6 if it begins in region two), in order on the single shared multiplier.
// Reset is synchronous and active low: it empties the queue, idles the sequencer and
// drops the output valid; no ellipse is active afterwards.

module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF,
    parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mer_cmd_if.sink    i_cmd,
    mer_pix_if.source  o_pix
);
    import mer_pkg::*;

    logic                      w_valid;
    logic                      w_pop;
    logic                      w_kind;
    logic [COORD_BITS-1:0]     w_cx;
    logic [COORD_BITS-1:0]     w_cy;
    logic [AXIS_BITS-1:0]      w_a;
    logic [AXIS_BITS-1:0]      w_b;
    logic                      w_emit_busy;
    t_emit_ctl                 w_ctl;
    logic [AXIS_BITS:0]        w_x;
    logic signed [AXIS_BITS:0] w_y;
    logic [COORD_BITS-1:0]     w_ox;
    logic [COORD_BITS-1:0]     w_oy;

    mer_front #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (w_valid),
        .i_pop   (w_pop),
        .o_kind  (w_kind),
        .o_cx    (w_cx),
        .o_cy    (w_cy),
        .o_a     (w_a),
        .o_b     (w_b)
    );

    mer_core #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid),
        .o_pop       (w_pop),
        .i_kind      (w_kind),
        .i_cx        (w_cx),
        .i_cy        (w_cy),
        .i_a         (w_a),
        .i_b         (w_b),
        .i_emit_busy (w_emit_busy),
        .o_ctl       (w_ctl),
        .o_x         (w_x),
        .o_y         (w_y),
        .o_ox        (w_ox),
        .o_oy        (w_oy)
    );

    mer_emit #(
        .COORD_BITS (COORD_BITS),
        .AXIS_BITS  (AXIS_BITS)
    ) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_ox    (w_ox),
        .i_oy    (w_oy),
        .o_busy  (w_emit_busy),
        .o_pix   (o_pix)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam longint CYCLE_LIMIT = 400000;
    localparam int     LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic               last;
    } t_pixel;

    class ellipse_tracker;
        t_pixel             pending_pixels[$];
        bit [11:0]          org_x;
        bit [11:0]          org_y;
        bit [21:0]          ax_sq;
        bit [21:0]          ay_sq;
        bit [11:0]          pt_x;
        logic signed [12:0] pt_y;
        logic signed [47:0] decision;
        bit                 region_two;
        bit                 busy;
        int                 errors;
        int                 checked;
        int                 commands;
        int                 ellipses_done;

        // Switches to region two when the slope passes -1 and ends the
        // ellipse once y has gone below zero.
        function void check_region();
            longint x, y, a2, b2;
            x  = pt_x;
            y  = pt_y;
            a2 = ax_sq;
            b2 = ay_sq;
            if (!region_two) begin
                if (2 * b2 * x < 2 * a2 * y) return;
                region_two = 1'b1;
                decision = 48'(b2 * (x * x + x) + b2 / 4 + a2 * (y - 1) * (y - 1) - a2 * b2);
            end
            if (y < 0) busy = 1'b0;
        endfunction

        function void advance_point();
            longint x, y, a2, b2, d;
            x  = pt_x;
            y  = pt_y;
            a2 = ax_sq;
            b2 = ay_sq;
            d  = decision;
            if (!region_two) begin
                x++;
                if (d < 0) begin
                    d += 2 * b2 * x + b2;
                end else begin
                    y--;
                    d += 2 * b2 * x - 2 * a2 * y + b2;
                end
            end else begin
                y--;
                if (d > 0) begin
                    d += a2 - 2 * a2 * y;
                end else begin
                    x++;
                    d += 2 * b2 * x - 2 * a2 * y + a2;
                end
            end
            pt_x     = x[11:0];
            pt_y     = y[12:0];
            decision = d[47:0];
        endfunction

        function t_pixel make_pixel(longint x, longint y, bit last);
            t_pixel p;
            p.x    = x[13:0];
            p.y    = y[13:0];
            p.last = last;
            return p;
        endfunction

        function void take_command(bit op, bit [11:0] cx, bit [11:0] cy,
                                   bit [10:0] rx, bit [10:0] ry);
            longint a, b, x, y, ox, oy;
            bit     last;
            commands++;
            if (op == mer_pkg::KIND_START) begin
                a          = rx;
                b          = ry;
                org_x      = cx;
                org_y      = cy;
                ax_sq      = 22'(a * a);
                ay_sq      = 22'(b * b);
                pt_x       = '0;
                pt_y       = b[12:0];
                region_two = 1'b0;
                busy       = 1'b1;
                decision   = 48'(b * b - a * a * b + (a * a) / 4);
                check_region();
                return;
            end
            if (!busy) return;
            x = pt_x;
            y = pt_y;
            advance_point();
            check_region();
            last = !busy;
            if (last) ellipses_done++;
            ox = org_x;
            oy = org_y;
            pending_pixels.push_back(make_pixel(ox + x, oy + y, 1'b0));
            pending_pixels.push_back(make_pixel(ox - x, oy + y, 1'b0));
            pending_pixels.push_back(make_pixel(ox + x, oy - y, 1'b0));
            pending_pixels.push_back(make_pixel(ox - x, oy - y, last));
        endfunction

        function void match_pixel(logic signed [13:0] px, logic signed [13:0] py, logic lp);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel x=%0d y=%0d last=%b", $time, px, py, lp);
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (px !== want.x || py !== want.y || lp !== want.last) begin
                errors++;
                $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%b,", $time,
                         want.x, want.y, want.last);
                $display("    got x=%0d y=%0d last=%b", px, py, lp);
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    bit     idles_on = 1'b1;
    int     items_sent;
    int     hold_requests;
    int     holds_served;
    int     hold_left;
    int     stall_left;
    longint cycles;

    ellipse_tracker tracker = new;

    mer_cmd_if cmd_if ();
    mer_pix_if pix_if ();

    midpoint_ellipse_rasterizer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pix   (pix_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pixels outstanding", $time,
                     tracker.pending_pixels.size());
            $display("** midpoint_ellipse_rasterizer: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_if.valid && pix_if.ready)
            tracker.match_pixel(pix_if.pixel_x, pix_if.pixel_y, pix_if.last_pixel);
        if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pix_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            pix_if.ready <= 1'b0;
        end else if (idles_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            pix_if.ready <= 1'b0;
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic op, input logic [11:0] cx, input logic [11:0] cy,
                             input logic [10:0] rx, input logic [10:0] ry);
        if (idles_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.opcode   <= op;
        cmd_if.center_x <= cx;
        cmd_if.center_y <= cy;
        cmd_if.radius_x <= rx;
        cmd_if.radius_y <= ry;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        tracker.take_command(op, cx, cy, rx, ry);
        items_sent++;
    endtask

    // The geometry fields of a step are ignored, so they carry random noise.
    task automatic send_step();
        send_item(mer_pkg::KIND_STEP, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                  11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
    endtask

    task automatic trace_ellipse(input int cap);
        int n;
        n = 0;
        while (tracker.busy && n < cap) begin
            send_step();
            n++;
        end
    endtask

    task automatic random_ellipse();
        int         kind;
        int         cap;
        logic [10:0] rx;
        logic [10:0] ry;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            rx  = 11'($urandom_range(0, 2047));
            ry  = 11'($urandom_range(0, 2047));
            cap = $urandom_range(1, 8);
        end else begin
            rx  = 11'($urandom_range(0, 12));
            ry  = 11'($urandom_range(0, 12));
            cap = (kind == 1) ? $urandom_range(1, 6) : 1000;
        end
        send_item(mer_pkg::KIND_START, 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), rx, ry);
        trace_ellipse(cap);
        repeat ($urandom_range(0, 2)) send_step();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.opcode   = mer_pkg::KIND_START;
        cmd_if.center_x = '0;
        cmd_if.center_y = '0;
        cmd_if.radius_x = '0;
        cmd_if.radius_y = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_step();
        send_item(mer_pkg::KIND_START, 12'd100, 12'd200, 11'd0, 11'd0);
        send_step();
        send_step();
        send_item(mer_pkg::KIND_START, 12'd4095, 12'd0, 11'd0, 11'd2);
        trace_ellipse(10);
        send_item(mer_pkg::KIND_START, 12'd0, 12'd4095, 11'd3, 11'd0);
        trace_ellipse(10);
        send_item(mer_pkg::KIND_START, 12'd4095, 12'd4095, 11'd2047, 11'd2047);
        trace_ellipse(3);
        send_item(mer_pkg::KIND_START, 12'd0, 12'd0, 11'd2047, 11'd1);
        trace_ellipse(3);
        send_item(mer_pkg::KIND_START, 12'd2048, 12'd1365, 11'd3, 11'd2);
        trace_ellipse(20);

        while (items_sent < 180) random_ellipse();

        // The output side stalls for a long stretch while up to forty steps of one
        // ellipse are being offered, so the input queue fills and backs up.
        hold_requests++;
        send_item(mer_pkg::KIND_START, 12'd2000, 12'd2000, 11'd30, 11'd30);
        trace_ellipse(40);

        idles_on = 1'b0;
        while (items_sent < 260) random_ellipse();
        cmd_if.valid <= 1'b0;

        while (tracker.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d transactions; checked %0d pixels; %0d ellipses traced to their last pixel.",
                 items_sent, tracker.checked, tracker.ellipses_done);
        if (tracker.pending_pixels.size() != 0) begin
            tracker.errors++;
            $display("%0t: %0d expected pixels never arrived", $time,
                     tracker.pending_pixels.size());
        end
        if (tracker.errors == 0) begin
            $display("** midpoint_ellipse_rasterizer: PASSED **");
        end else begin
            $display("%0d errors found.", tracker.errors);
            $display("** midpoint_ellipse_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mer_pkg.sv
rtl/mer_if.sv
rtl/mer_front.sv
rtl/mer_core.sv
rtl/mer_emit.sv
rtl/midpoint_ellipse_rasterizer.sv
tb/tb.sv
